>>> sv/mwo_pkg.sv
// Package for the mecanum wheel odometry core: shared constants, codes and types.
// Used by mwo_arith and mecanum_wheel_odometry_core; depends on nothing else.
package mwo_pkg;

    localparam logic [29:0] NSEC_PER_SEC = 30'd1000000000;

    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int DEN_W   = 47;
    localparam int QUO_W   = 32;
    localparam int K_W     = 62;

    localparam int          CFG_IDX_W          = 2;
    localparam logic [1:0]  CFG_TICK_TO_RADIAN = 2'd0;
    localparam logic [1:0]  CFG_WHEEL_RADIUS   = 2'd1;
    localparam logic [1:0]  CFG_HALF_L_PLUS_W  = 2'd2;

    localparam logic [31:0] TICK_TO_RADIAN_RST = 32'd128505122;
    localparam logic [15:0] WHEEL_RADIUS_RST   = 16'd4588;
    localparam logic [17:0] HALF_L_PLUS_W_RST  = 18'd24183;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_GAP     = 2'd1,
        ST_ZERO_DT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ACC_HOLD     = 3'd0,
        ACC_LOAD     = 3'd1,
        ACC_ADD      = 3'd2,
        ACC_DIV_INIT = 3'd3,
        ACC_DIV_STEP = 3'd4
    } acc_op_t;

    typedef struct packed {
        logic               mul_en;
        acc_op_t            op;
        logic [1:0]         sh;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
        logic [DEN_W-1:0]   den;
    } arith_cmd_t;

endpackage

>>> sv/mecanum_wheel_odometry_core.sv
// Mecanum wheel odometry core: wheel rates and body velocities from encoder samples.
// Depends on mwo_pkg and instantiates the shared arithmetic unit mwo_arith.
//
//   channel  handshake                 words carried
//   cfg      cfg_valid / cfg_ready     cfg_index, cfg_data (register write)
//   sample   sample_valid / _stall     stamp, sequence number, four wheel positions
//   result   result_valid / _stall     velocity_x, velocity_y, yaw_rate, copies, status
//
// A primed sample occupies the core for passes of the 32-step divider (four wheels and,
// when the half L plus W constant is non-zero, yaw) plus the multiply and bookkeeping
// steps; its result word is presented when the core finishes.
// The first sample after reset gives no result; a zero interval skips the arithmetic.
// Reset is asynchronous and active low and needs no clearing pass.
// A new sample is taken as soon as the previous result is in the output register.
module mecanum_wheel_odometry_core
    import mwo_pkg::*;
#(
    parameter int TICK_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [CFG_IDX_W-1:0]         cfg_index,
    input  logic [31:0]                  cfg_data,
    input  logic                         sample_valid,
    output logic                         sample_stall,
    input  logic [31:0]                  stamp_sec,
    input  logic [29:0]                  stamp_nsec,
    input  logic [31:0]                  sequence_number,
    input  logic signed [TICK_WIDTH-1:0] ticks_front_left,
    input  logic signed [TICK_WIDTH-1:0] ticks_front_right,
    input  logic signed [TICK_WIDTH-1:0] ticks_rear_left,
    input  logic signed [TICK_WIDTH-1:0] ticks_rear_right,
    output logic                         result_valid,
    input  logic                         result_stall,
    output logic signed [31:0]           velocity_x,
    output logic signed [31:0]           velocity_y,
    output logic signed [31:0]           yaw_rate,
    output logic [31:0]                  out_sequence,
    output logic [31:0]                  out_sec,
    output logic [29:0]                  out_nsec,
    output logic [1:0]                   status
);

    localparam int ACC_W = (TICK_WIDTH + K_W > 80) ? TICK_WIDTH + K_W : 80;

    typedef enum logic [11:0] {
        S_IDLE     = 12'b0000_0000_0001,
        S_PREP     = 12'b0000_0000_0010,
        S_W_PREP   = 12'b0000_0000_0100,
        S_W_MUL    = 12'b0000_0000_1000,
        S_W_ACC    = 12'b0000_0001_0000,
        S_DIV_INIT = 12'b0000_0010_0000,
        S_DIV      = 12'b0000_0100_0000,
        S_DIV_DONE = 12'b0000_1000_0000,
        S_KIN      = 12'b0001_0000_0000,
        S_A_MUL    = 12'b0010_0000_0000,
        S_A_LOAD   = 12'b0100_0000_0000,
        S_FIN      = 12'b1000_0000_0000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [1:0]              widx_reg;
    logic [1:0]              aidx_reg;
    logic [1:0]              pp_reg;
    logic [4:0]              step_reg;
    logic                    yaw_phase_reg;
    logic                    have_prev_reg;
    logic                    result_valid_reg;

    logic [31:0]             ttr_reg;
    logic [15:0]             radius_reg;
    logic [17:0]             lw_reg;

    logic [31:0]             prev_sec_reg;
    logic [29:0]             prev_nsec_reg;
    logic [TICK_WIDTH-1:0]   prev_ticks_reg [4];

    logic [31:0]             cur_sec_reg;
    logic [29:0]             cur_nsec_reg;
    logic [31:0]             cur_seq_reg;
    logic [TICK_WIDTH-1:0]   cur_ticks_reg [4];

    logic                    dt_neg_reg;
    logic [30:0]             dmag_reg;
    status_t                 status_reg;
    logic [K_W-1:0]          k_reg;
    logic [TICK_WIDTH-1:0]   mag_reg;
    logic                    neg_reg;
    logic [31:0]             wheel_reg [4];
    logic [MUL_A_W-1:0]      sum_reg [3];
    logic [31:0]             vel_reg [3];

    logic [31:0]             vx_out_reg;
    logic [31:0]             vy_out_reg;
    logic [31:0]             wz_out_reg;
    logic [31:0]             seq_out_reg;
    logic [31:0]             sec_out_reg;
    logic [29:0]             nsec_out_reg;
    status_t                 status_out_reg;

    arith_cmd_t              cmd;
    logic [PROD_W-1:0]       prod;
    logic [QUO_W-1:0]        quo;
    logic                    ovf;

    logic                    sample_take;
    logic                    fin_go;
    logic [TICK_WIDTH-1:0]   cur_tick;
    logic [TICK_WIDTH-1:0]   prev_tick;
    logic [TICK_WIDTH:0]     delta;
    logic [TICK_WIDTH:0]     delta_abs;
    logic [63:0]             mag_wide;
    logic signed [32:0]      dt;
    logic [32:0]             dt_abs;
    logic                    dt_zero;
    logic                    sec_gap;
    logic [MUL_A_W-1:0]      ext [4];
    logic [MUL_A_W-1:0]      ax;
    logic [MUL_A_W-1:0]      ax_abs;
    logic [31:0]             limit;
    logic [31:0]             rate;
    logic [31:0]             rate_signed;
    logic [31:0]             q_xy;
    logic [31:0]             res_xy;

    mwo_arith #(
        .ACC_W (ACC_W)
    ) u_arith (
        .clk  (clk),
        .cmd  (cmd),
        .prod (prod),
        .quo  (quo),
        .ovf  (ovf)
    );

    assign sample_take = sample_valid && (state_reg == S_IDLE);
    assign fin_go      = !result_valid_reg || !result_stall;

    always_comb
    begin
        cur_tick  = cur_ticks_reg[widx_reg];
        prev_tick = prev_ticks_reg[widx_reg];
        delta     = {cur_tick[TICK_WIDTH-1], cur_tick} - {prev_tick[TICK_WIDTH-1], prev_tick};
        delta_abs = delta[TICK_WIDTH] ? (~delta + 1'b1) : delta;
        mag_wide  = 64'(mag_reg);

        if (cur_sec_reg == prev_sec_reg)
        begin
            dt = $signed({3'b000, cur_nsec_reg}) - $signed({3'b000, prev_nsec_reg});
        end
        else
        begin
            dt = $signed({3'b000, NSEC_PER_SEC}) - $signed({3'b000, prev_nsec_reg})
                 + $signed({3'b000, cur_nsec_reg});
        end
        dt_abs  = dt[32] ? (~dt + 1'b1) : dt;
        dt_zero = (dt == 33'sd0);
        sec_gap = (cur_sec_reg - prev_sec_reg) > 32'd1;

        for (int i = 0; i < 4; i++)
        begin
            ext[i] = {{2{wheel_reg[i][31]}}, wheel_reg[i]};
        end
        ax     = sum_reg[aidx_reg];
        ax_abs = ax[MUL_A_W-1] ? (~ax + 1'b1) : ax;

        limit       = neg_reg ? 32'h8000_0000 : 32'h7fff_ffff;
        rate        = (ovf || (quo > limit)) ? limit : quo;
        rate_signed = neg_reg ? (~rate + 32'd1) : rate;
        q_xy        = prod[49:18];
        res_xy      = neg_reg ? (~q_xy + 32'd1) : q_xy;
    end

    always_comb
    begin
        cmd        = '0;
        cmd.op     = ACC_HOLD;
        cmd.den    = yaw_phase_reg ? {{(DEN_W-20){1'b0}}, lw_reg, 2'b00} : {dmag_reg, 16'h0000};
        unique case (state_reg)
            S_PREP:
            begin
                cmd.mul_en = 1'b1;
                cmd.a      = {2'b00, ttr_reg};
                cmd.b      = {2'b00, NSEC_PER_SEC};
            end
            S_W_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.a      = pp_reg[1] ? {2'b00, mag_wide[63:32]} : {2'b00, mag_wide[31:0]};
                cmd.b      = pp_reg[0] ? {2'b00, k_reg[K_W-1:32]} : k_reg[31:0];
                cmd.sh     = {1'b0, pp_reg[1]} + {1'b0, pp_reg[0]};
                if (pp_reg == 2'd0)
                begin
                    cmd.op = ACC_HOLD;
                end
                else if (pp_reg == 2'd1)
                begin
                    cmd.op = ACC_LOAD;
                end
                else
                begin
                    cmd.op = ACC_ADD;
                end
            end
            S_W_ACC:
            begin
                cmd.op = ACC_ADD;
            end
            S_DIV_INIT:
            begin
                cmd.op = ACC_DIV_INIT;
            end
            S_DIV:
            begin
                cmd.op = ACC_DIV_STEP;
            end
            S_A_MUL:
            begin
                cmd.mul_en = 1'b1;
                cmd.a      = ax_abs;
                cmd.b      = {16'h0000, radius_reg};
            end
            S_A_LOAD:
            begin
                cmd.op = ACC_LOAD;
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                if (!have_prev_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (dt_zero)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_W_PREP;
                end
            end
            S_W_PREP:
            begin
                state_next = S_W_MUL;
            end
            S_W_MUL:
            begin
                if (pp_reg == 2'd3)
                begin
                    state_next = S_W_ACC;
                end
            end
            S_W_ACC:
            begin
                state_next = S_DIV_INIT;
            end
            S_DIV_INIT:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (step_reg == 5'd31)
                begin
                    state_next = S_DIV_DONE;
                end
            end
            S_DIV_DONE:
            begin
                if (yaw_phase_reg)
                begin
                    state_next = S_FIN;
                end
                else if (widx_reg == 2'd3)
                begin
                    state_next = S_KIN;
                end
                else
                begin
                    state_next = S_W_PREP;
                end
            end
            S_KIN:
            begin
                state_next = S_A_MUL;
            end
            S_A_MUL:
            begin
                state_next = S_A_LOAD;
            end
            S_A_LOAD:
            begin
                if (aidx_reg != 2'd2)
                begin
                    state_next = S_A_MUL;
                end
                else if (lw_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DIV_INIT;
                end
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            widx_reg         <= '0;
            aidx_reg         <= '0;
            pp_reg           <= '0;
            step_reg         <= '0;
            yaw_phase_reg    <= 1'b0;
            have_prev_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
            ttr_reg          <= TICK_TO_RADIAN_RST;
            radius_reg       <= WHEEL_RADIUS_RST;
            lw_reg           <= HALF_L_PLUS_W_RST;
            prev_sec_reg     <= '0;
            prev_nsec_reg    <= '0;
            for (int i = 0; i < 4; i++)
            begin
                prev_ticks_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_TICK_TO_RADIAN: ttr_reg    <= cfg_data;
                    CFG_WHEEL_RADIUS:   radius_reg <= cfg_data[15:0];
                    CFG_HALF_L_PLUS_W:  lw_reg     <= cfg_data[17:0];
                    default:
                    begin
                    end
                endcase
            end

            if ((state_reg == S_FIN) && fin_go)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_PREP:
                begin
                    widx_reg      <= '0;
                    yaw_phase_reg <= 1'b0;
                    if (!have_prev_reg)
                    begin
                        have_prev_reg <= 1'b1;
                        prev_sec_reg  <= cur_sec_reg;
                        prev_nsec_reg <= cur_nsec_reg;
                        prev_ticks_reg <= cur_ticks_reg;
                    end
                end
                S_W_MUL:
                begin
                    pp_reg <= pp_reg + 2'd1;
                end
                S_DIV_INIT:
                begin
                    step_reg <= '0;
                end
                S_DIV:
                begin
                    step_reg <= step_reg + 5'd1;
                end
                S_DIV_DONE:
                begin
                    if (!yaw_phase_reg)
                    begin
                        widx_reg <= widx_reg + 2'd1;
                    end
                end
                S_KIN:
                begin
                    aidx_reg <= '0;
                end
                S_A_LOAD:
                begin
                    if (aidx_reg != 2'd2)
                    begin
                        aidx_reg <= aidx_reg + 2'd1;
                    end
                    else
                    begin
                        yaw_phase_reg <= 1'b1;
                    end
                end
                S_FIN:
                begin
                    if (fin_go)
                    begin
                        prev_sec_reg     <= cur_sec_reg;
                        prev_nsec_reg    <= cur_nsec_reg;
                        prev_ticks_reg   <= cur_ticks_reg;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
        begin
            cur_sec_reg      <= stamp_sec;
            cur_nsec_reg     <= stamp_nsec;
            cur_seq_reg      <= sequence_number;
            cur_ticks_reg[0] <= ticks_front_left;
            cur_ticks_reg[1] <= ticks_front_right;
            cur_ticks_reg[2] <= ticks_rear_left;
            cur_ticks_reg[3] <= ticks_rear_right;
        end

        unique case (state_reg)
            S_PREP:
            begin
                dt_neg_reg <= dt[32];
                dmag_reg   <= dt_abs[30:0];
                if (dt_zero)
                begin
                    status_reg <= ST_ZERO_DT;
                    for (int i = 0; i < 3; i++)
                    begin
                        vel_reg[i] <= '0;
                    end
                end
                else
                begin
                    status_reg <= sec_gap ? ST_GAP : ST_OK;
                end
            end
            S_W_PREP:
            begin
                if (widx_reg == 2'd0)
                begin
                    k_reg <= prod[K_W-1:0];
                end
                mag_reg <= delta_abs[TICK_WIDTH-1:0];
                neg_reg <= delta[TICK_WIDTH] ^ dt_neg_reg;
            end
            S_DIV_DONE:
            begin
                if (yaw_phase_reg)
                begin
                    vel_reg[2] <= rate_signed;
                end
                else
                begin
                    wheel_reg[widx_reg] <= rate_signed;
                end
            end
            S_KIN:
            begin
                sum_reg[0] <= ext[0] + ext[1] + ext[2] + ext[3];
                sum_reg[1] <= ext[1] + ext[2] - ext[0] - ext[3];
                sum_reg[2] <= ext[1] + ext[3] - ext[0] - ext[2];
            end
            S_A_MUL:
            begin
                neg_reg <= ax[MUL_A_W-1];
            end
            S_A_LOAD:
            begin
                if (aidx_reg != 2'd2)
                begin
                    vel_reg[aidx_reg] <= res_xy;
                end
                else if (lw_reg == '0)
                begin
                    vel_reg[2] <= '0;
                end
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    vx_out_reg     <= vel_reg[0];
                    vy_out_reg     <= vel_reg[1];
                    wz_out_reg     <= vel_reg[2];
                    seq_out_reg    <= cur_seq_reg;
                    sec_out_reg    <= cur_sec_reg;
                    nsec_out_reg   <= cur_nsec_reg;
                    status_out_reg <= status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign cfg_ready    = 1'b1;
    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign velocity_x   = vx_out_reg;
    assign velocity_y   = vy_out_reg;
    assign yaw_rate     = wz_out_reg;
    assign out_sequence = seq_out_reg;
    assign out_sec      = sec_out_reg;
    assign out_nsec     = nsec_out_reg;
    assign status       = status_out_reg;

`ifndef NO_ASSERTIONS
    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_FIN))
        else $error("Result word raised outside the final step.");

    a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN) && result_valid && result_stall |=> (state_reg == S_FIN))
        else $error("Final step overran a stalled result word.");

    a_primed_stays: assert property (@(posedge clk) disable iff (!rst_n)
        have_prev_reg |=> have_prev_reg)
        else $error("Previous sample flag was lost.");

    a_zero_dt_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (status == ST_ZERO_DT) |->
        (velocity_x == 32'sd0) && (velocity_y == 32'sd0) && (yaw_rate == 32'sd0))
        else $error("Zero interval word carries non-zero velocities.");
`endif

endmodule

>>> sv/mwo_arith.sv
// Shared arithmetic unit: a registered 34 x 32 multiplier, a shifting accumulator
// and a one-bit-per-cycle restoring divider. Depends on mwo_pkg.
module mwo_arith
    import mwo_pkg::*;
#(
    parameter int ACC_W = 80
)
(
    input  logic              clk,
    input  arith_cmd_t        cmd,
    output logic [PROD_W-1:0] prod,
    output logic [QUO_W-1:0]  quo,
    output logic              ovf
);

    logic [PROD_W-1:0] prod_reg;
    logic [1:0]        sh_reg;
    logic [ACC_W-1:0]  acc_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [QUO_W-1:0]  dvd_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic              ovf_reg;

    logic [ACC_W-1:0]  addend;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fits;
    logic              ovf_next;

    always_comb
    begin
        addend   = ACC_W'(prod_reg) << {sh_reg, 5'b00000};
        trial    = {rem_reg, dvd_reg[QUO_W-1]};
        diff     = trial - {1'b0, cmd.den};
        fits     = trial >= {1'b0, cmd.den};
        ovf_next = (|acc_reg[ACC_W-1:32+DEN_W]) || (acc_reg[32+DEN_W-1:32] >= cmd.den);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod_reg <= PROD_W'(cmd.a) * PROD_W'(cmd.b);
            sh_reg   <= cmd.sh;
        end
        unique case (cmd.op)
            ACC_HOLD:
            begin
            end
            ACC_LOAD:
            begin
                acc_reg <= addend;
            end
            ACC_ADD:
            begin
                acc_reg <= acc_reg + addend;
            end
            ACC_DIV_INIT:
            begin
                rem_reg <= acc_reg[32+DEN_W-1:32];
                dvd_reg <= acc_reg[QUO_W-1:0];
                quo_reg <= '0;
                ovf_reg <= ovf_next;
            end
            ACC_DIV_STEP:
            begin
                rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                dvd_reg <= {dvd_reg[QUO_W-2:0], 1'b0};
                quo_reg <= {quo_reg[QUO_W-2:0], fits};
            end
            default:
            begin
            end
        endcase
    end

    assign prod = prod_reg;
    assign quo  = quo_reg;
    assign ovf  = ovf_reg;

endmodule
